@@ hdl/ratio_to_bounded_fraction_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ratio to bounded fraction block
// Concurrent assertion helpers, clocked on a rising edge, masked in reset.
// ---------------------------------------------------------------------------
`ifndef RATIO_TO_BOUNDED_FRACTION_TOP_ASSERT_SVH
`define RATIO_TO_BOUNDED_FRACTION_TOP_ASSERT_SVH

// same-cycle implication
`define RBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rbf_pkg.sv @@
// ---------------------------------------------------------------------------
// rbf_pkg
// Types, constants and the control store of the ratio to bounded fraction
// sequencer.
// ---------------------------------------------------------------------------
package rbf_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned RAW_W         = 31;
    localparam int unsigned Q_W           = 10;
    localparam int unsigned PROD_W        = Q_W + RAW_W;
    localparam int unsigned SUM_W         = PROD_W + 1;
    localparam int unsigned NUM_MAX       = 1000;
    localparam logic [Q_W-1:0] CAP_RESET  = 10'd100;
    localparam logic REG_IDX_MAX_DEN      = 1'b0;

    localparam int unsigned STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_INIT  = 4'd0;
    localparam step_t STEP_TEST  = 4'd1;
    localparam step_t STEP_DIVLD = 4'd2;
    localparam step_t STEP_DIVIT = 4'd3;
    localparam step_t STEP_MULQ  = 4'd4;
    localparam step_t STEP_CHECK = 4'd5;
    localparam step_t STEP_ADV   = 4'd6;
    localparam step_t STEP_FIN   = 4'd7;
    localparam step_t STEP_RND   = 4'd8;
    localparam step_t STEP_ERR   = 4'd9;
    localparam step_t STEP_EMIT  = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_DIVLD,
        OP_DIVIT,
        OP_MULQ,
        OP_MULR,
        OP_ADV,
        OP_RND,
        OP_ERR,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NEG,
        COND_EXIT,
        COND_DIV_MORE,
        COND_OVER,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t rom_word(input step_t pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: COND_NEVER, target: STEP_INIT};
        case (pc)
            STEP_INIT:  w = '{op: OP_INIT,  cond: COND_NEG,      target: STEP_ERR};
            STEP_TEST:  w = '{op: OP_NOP,   cond: COND_EXIT,     target: STEP_FIN};
            STEP_DIVLD: w = '{op: OP_DIVLD, cond: COND_NEVER,    target: STEP_INIT};
            STEP_DIVIT: w = '{op: OP_DIVIT, cond: COND_DIV_MORE, target: STEP_DIVIT};
            STEP_MULQ:  w = '{op: OP_MULQ,  cond: COND_NEVER,    target: STEP_INIT};
            STEP_CHECK: w = '{op: OP_NOP,   cond: COND_OVER,     target: STEP_FIN};
            STEP_ADV:   w = '{op: OP_ADV,   cond: COND_ALWAYS,   target: STEP_TEST};
            STEP_FIN:   w = '{op: OP_MULR,  cond: COND_NEVER,    target: STEP_INIT};
            STEP_RND:   w = '{op: OP_RND,   cond: COND_ALWAYS,   target: STEP_EMIT};
            STEP_ERR:   w = '{op: OP_ERR,   cond: COND_NEVER,    target: STEP_INIT};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY, target: STEP_EMIT};
            default:    w = '{op: OP_NOP,   cond: COND_NEVER,    target: STEP_INIT};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/ratio_to_bounded_fraction_top.sv @@
// Sequence: a check for a non-positive input, then convergent steps until the
// remainder is zero or the cap stops them, then a final multiply and rounding.
// Each step runs a bit-serial restoring division of FRAC_BITS+1 quotient bits.
// Throughput: one item at a time; the next item is accepted once the result
// is handed to the output register, which holds it until taken.
// Reset: synchronous on aresetn low; the cap returns to 100, no result pending.
// ---------------------------------------------------------------------------
// ratio_to_bounded_fraction_top
// Converts a positive fixed-point ratio into numerator/denominator with a
// capped denominator, using a microcoded sequencer over a small datapath.
// ---------------------------------------------------------------------------
module ratio_to_bounded_fraction_top
    import rbf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_ratio_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_numerator,
    output logic [9:0]  m_denominator,
    output logic        m_not_positive,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned W  = FRAC_BITS + 1;
    localparam int unsigned CW = $clog2(W + 1);

    logic [Q_W-1:0]    cap_reg, cap_next;
    logic              busy_reg, busy_next;
    step_t             pc_reg, pc_next;
    logic [31:0]       raw_reg, raw_next;
    logic [W-1:0]      num_reg, num_next;
    logic [W-1:0]      den_reg, den_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [Q_W-1:0]    prev_reg, prev_next;
    logic [Q_W-1:0]    cur_reg, cur_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [Q_W-1:0]    res_num_reg, res_num_next;
    logic [Q_W-1:0]    res_den_reg, res_den_next;
    logic              res_neg_reg, res_neg_next;
    logic              m_valid_reg, m_valid_next;
    logic [Q_W-1:0]    m_num_reg, m_num_next;
    logic [Q_W-1:0]    m_den_reg, m_den_next;
    logic              m_neg_reg, m_neg_next;

    ctrl_t             cw;
    logic              cond_hit;
    logic              out_free;
    logic              is_neg;
    logic [W-1:0]      rem_sh;
    logic              div_ge;
    logic [RAW_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [SUM_W-1:0]  next_q;
    logic [SUM_W-1:0]  rnd_sum;
    logic [SUM_W-1:0]  rnd_t;
    logic [Q_W-1:0]    rnd_sat;
    logic              cfg_wr;

    assign cw       = rom_word(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign is_neg   = (raw_reg == 32'd0) || raw_reg[31];

    assign rem_sh = {rem_reg[W-2:0], quo_reg[W-1]};
    assign div_ge = rem_sh >= num_reg;

    assign mul_b  = (cw.op == OP_MULR) ? raw_reg[RAW_W-1:0] : RAW_W'(quo_reg);
    assign mul_p  = PROD_W'(cur_reg) * PROD_W'(mul_b);
    assign next_q = {1'b0, prod_reg} + SUM_W'(prev_reg);

    assign rnd_sum = {1'b0, prod_reg} + (SUM_W'(1) << (FRAC_BITS - 1));
    assign rnd_t   = rnd_sum >> FRAC_BITS;

    always_comb begin
        if (rnd_t == '0) begin
            rnd_sat = Q_W'(1);
        end else if (rnd_t > SUM_W'(NUM_MAX)) begin
            rnd_sat = Q_W'(NUM_MAX);
        end else begin
            rnd_sat = rnd_t[Q_W-1:0];
        end
    end

    always_comb begin
        case (cw.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NEG:      cond_hit = is_neg;
            COND_EXIT:     cond_hit = (num_reg == '0) || (cur_reg >= cap_reg);
            COND_DIV_MORE: cond_hit = cnt_reg != CW'(1);
            COND_OVER:     cond_hit = next_q > SUM_W'(cap_reg);
            COND_OUT_BUSY: cond_hit = !out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        cap_next     = cap_reg;
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        raw_next     = raw_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        prod_next    = prod_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_neg_next = res_neg_reg;
        m_valid_next = m_valid_reg;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_neg_next   = m_neg_reg;

        if (cfg_wr && (paddr[2] == REG_IDX_MAX_DEN)) begin
            cap_next = pwdata[Q_W-1:0];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (!busy_reg) begin
            if (s_valid) begin
                busy_next = 1'b1;
                pc_next   = STEP_INIT;
                raw_next  = s_ratio_value;
            end
        end else begin
            pc_next = cond_hit ? cw.target : step_t'(pc_reg + step_t'(1));
            case (cw.op)
                OP_INIT: begin
                    num_next  = {1'b0, raw_reg[FRAC_BITS-1:0]};
                    den_next  = {1'b1, {FRAC_BITS{1'b0}}};
                    prev_next = '0;
                    cur_next  = Q_W'(1);
                end
                OP_DIVLD: begin
                    rem_next = '0;
                    quo_next = den_reg;
                    cnt_next = CW'(W);
                end
                OP_DIVIT: begin
                    rem_next = div_ge ? (rem_sh - num_reg) : rem_sh;
                    quo_next = {quo_reg[W-2:0], div_ge};
                    cnt_next = cnt_reg - CW'(1);
                end
                OP_MULQ, OP_MULR: begin
                    prod_next = mul_p;
                end
                OP_ADV: begin
                    prev_next = cur_reg;
                    cur_next  = next_q[Q_W-1:0];
                    den_next  = num_reg;
                    num_next  = rem_reg;
                end
                OP_RND: begin
                    res_num_next = rnd_sat;
                    res_den_next = cur_reg;
                    res_neg_next = 1'b0;
                end
                OP_ERR: begin
                    res_num_next = Q_W'(1);
                    res_den_next = Q_W'(1);
                    res_neg_next = 1'b1;
                end
                OP_EMIT: begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_num_next   = res_num_reg;
                        m_den_next   = res_den_reg;
                        m_neg_next   = res_neg_reg;
                        busy_next    = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            busy_reg    <= 1'b0;
            pc_reg      <= STEP_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            cap_reg     <= cap_next;
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg     <= raw_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        prod_reg    <= prod_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_neg_reg <= res_neg_next;
        m_num_reg   <= m_num_next;
        m_den_reg   <= m_den_next;
        m_neg_reg   <= m_neg_next;
    end

    assign s_ready        = !busy_reg;
    assign m_valid        = m_valid_reg;
    assign m_numerator    = m_num_reg;
    assign m_denominator  = m_den_reg;
    assign m_not_positive = m_neg_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_MAX_DEN) ? 32'(cap_reg) : 32'd0;

endmodule

@@ hdl/rbf_checker.sv @@
// ---------------------------------------------------------------------------
// rbf_checker
// Port-level checks on the ratio to bounded fraction block, bound to the top.
// ---------------------------------------------------------------------------
`include "ratio_to_bounded_fraction_top_assert.svh"

module rbf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_numerator,
    input logic [9:0] m_denominator,
    input logic       m_not_positive
);

    `RBF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_numerator) && $stable(m_denominator), "result item dropped")

    `RBF_ASSERT_NOW(a_err_fields, aclk, aresetn, m_valid && m_not_positive,
        m_numerator == 10'd1 && m_denominator == 10'd1, "error item fields not 1/1")

    `RBF_ASSERT_NOW(a_range, aclk, aresetn, m_valid && !m_not_positive,
        m_numerator >= 10'd1 && m_numerator <= 10'd1000 && m_denominator >= 10'd1,
        "result item out of range")

    `RBF_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready,
        !s_ready, "item accepted while sequencer busy")

endmodule

bind ratio_to_bounded_fraction_top rbf_checker u_rbf_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_numerator    (m_numerator),
    .m_denominator  (m_denominator),
    .m_not_positive (m_not_positive)
);

@@ tb/sv/tb_ratio_to_bounded_fraction_top.sv @@
// ---------------------------------------------------------------------------
// tb_ratio_to_bounded_fraction_top
// Drives fixed-point ratios into the bounded fraction converter under random
// input gaps and output stalls, predicts each numerator/denominator pair from
// the convergent recurrence, and compares every result in arrival order.
// The denominator cap is reprogrammed over APB between phases, extremes
// included, and one phase stalls the output long enough to back up the input.
// ---------------------------------------------------------------------------
module tb_ratio_to_bounded_fraction_top;
    import rbf_pkg::*;

    localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;
    localparam longint unsigned SCALE = 64'd1 << FRAC_BITS;
    localparam int unsigned NUM_MIN = 1;
    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 400;
    localparam int RANDOM_ITEMS = 700;
    localparam int PHASE_ITEMS = 100;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam logic [2:0] ADDR_MAX_DEN = {REG_IDX_MAX_DEN, 2'b00};

    typedef struct packed {
        logic [9:0] numerator;
        logic [9:0] denominator;
        logic       not_positive;
    } fraction_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_ratio_value;
    logic        m_valid;
    logic        m_ready;
    logic [9:0]  m_numerator;
    logic [9:0]  m_denominator;
    logic        m_not_positive;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fraction_t   expected_fractions[$];
    logic [9:0]  cap_model;
    int          mismatches;
    int          tx_gap_max;
    int          rx_gap_max;
    int          rx_stall;
    bit          hold_pending;

    ratio_to_bounded_fraction_top #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ratio_value (s_ratio_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_numerator   (m_numerator),
        .m_denominator (m_denominator),
        .m_not_positive(m_not_positive),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic fraction_t bounded_fraction(input logic [31:0] raw,
                                                   input logic [9:0] cap_r);
        longint unsigned rem_num, rem_den, q_prev, q_cur, q_next, quot, rem, cap, num;
        fraction_t f;
        if (raw == 32'd0 || raw[31]) begin
            f = '{numerator: 10'd1, denominator: 10'd1, not_positive: 1'b1};
            return f;
        end
        cap = cap_r;
        rem_num = raw % SCALE;
        rem_den = SCALE;
        q_prev = 0;
        q_cur = 1;
        while (rem_num > 0 && q_cur < cap) begin
            quot = rem_den / rem_num;
            rem = rem_den % rem_num;
            q_next = q_prev + q_cur * quot;
            if (q_next > cap)
                break;
            q_prev = q_cur;
            q_cur = q_next;
            rem_den = rem_num;
            rem_num = rem;
        end
        num = (q_cur * raw + SCALE / 2) / SCALE;
        if (num < NUM_MIN)
            num = NUM_MIN;
        if (num > NUM_MAX)
            num = NUM_MAX;
        f.numerator = num[9:0];
        f.denominator = q_cur[9:0];
        f.not_positive = 1'b0;
        return f;
    endfunction

    function automatic logic [31:0] rand_ratio();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = ($urandom_range(0, 3) == 0) ? 32'd0 : {1'b1, 31'($urandom)};
            2: v = 32'($urandom_range(1, 2000)) << FRAC_BITS;
            3: v = 32'($urandom_range(1, 65535));
            default: v = {16'($urandom_range(0, 1100)), 16'($urandom)};
        endcase
        return v;
    endfunction

    task automatic send_ratio(input logic [31:0] v);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ratio_value <= v;
        do @(posedge aclk); while (!s_ready);
        expected_fractions.push_back(bounded_fraction(v, cap_model));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_fractions.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cap(input logic [9:0] v);
        drain_results();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_DEN;
        pwdata <= {22'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cap_model = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // result sink: random stalls, plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                rx_stall = HOLD_CYCLES;
            end else if (m_valid && m_ready) begin
                rx_stall = $urandom_range(0, rx_gap_max);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_ready <= (rx_stall == 0);
        end
    end

    always @(posedge aclk) begin
        fraction_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{numerator: m_numerator, denominator: m_denominator,
                    not_positive: m_not_positive};
            if (expected_fractions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: num=%0d den=%0d np=%0b",
                             got.numerator, got.denominator, got.not_positive);
            end else begin
                want = expected_fractions.pop_front();
                if (got.numerator !== want.numerator ||
                    got.denominator !== want.denominator ||
                    got.not_positive !== want.not_positive) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected num=%0d den=%0d np=%0b, got num=%0d den=%0d np=%0b",
                                 want.numerator, want.denominator, want.not_positive,
                                 got.numerator, got.denominator, got.not_positive);
                end
            end
        end
    end

    task automatic test_reset_cap();
        tx_gap_max = 16;
        rx_gap_max = 16;
        send_ratio(32'd0);
        send_ratio(32'hFFFF_FFFF);
        send_ratio(32'h8000_0000);
        send_ratio(32'h7FFF_FFFF);
        send_ratio(32'h0003_0000);
        send_ratio(32'h0000_0001);
        send_ratio(32'h0000_8000);
        send_ratio(32'h0003_243F);
        send_ratio(32'h0001_9E37);
        send_ratio(32'h0000_5555);
        send_ratio(32'h03E8_8000);
        send_ratio(32'h0001_0000);
    endtask

    task automatic test_cap_extremes();
        logic [9:0] caps[4];
        caps = '{10'd1, 10'd0, 10'd1000, 10'd1023};
        tx_gap_max = 0;
        rx_gap_max = 0;
        foreach (caps[i]) begin
            write_cap(caps[i]);
            send_ratio(32'h0003_243F);
            send_ratio(32'h0001_9E37);
            send_ratio(32'h0000_0007);
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        tx_gap_max = 0;
        hold_pending = 1'b1;
        repeat (8) send_ratio(rand_ratio());
    endtask

    task automatic test_random();
        int r;
        for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
            r = $urandom_range(0, 7);
            case (r)
                0: write_cap(10'd0);
                1: write_cap(10'd1);
                2: write_cap(10'd1000);
                3: write_cap(10'd1023);
                default: write_cap(10'($urandom_range(2, 999)));
            endcase
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            repeat (PHASE_ITEMS) send_ratio(rand_ratio());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ratio_value = 32'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_pending = 1'b0;
        cap_model = CAP_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_cap();
        test_cap_extremes();
        test_backpressure();
        test_random();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_fractions.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 4);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rbf_pkg.sv
hdl/ratio_to_bounded_fraction_top.sv
hdl/rbf_checker.sv
tb/sv/tb_ratio_to_bounded_fraction_top.sv
